// ===== rtl/core/mexp_pkg.sv =====
// mexp_pkg: payload types and field widths for the modular exponentiation block
// no dependencies; used by modular_exponentiation and tb_top
`timescale 1ns / 1ps

package mexp_pkg;

  // widths of the payload fields on the ports
  localparam int unsigned FIELD_VALUE_BITS = 32;
  localparam int unsigned FIELD_POWER_BITS = 31;

  // input transaction payload
  typedef struct packed {
    logic [FIELD_VALUE_BITS-1:0] base_value;
    logic [FIELD_POWER_BITS-1:0] power;
    logic [FIELD_VALUE_BITS-1:0] modulus;
  } mexp_in_t;

  // result transaction payload
  typedef struct packed {
    logic [FIELD_VALUE_BITS-1:0] residue;
    logic                        zero_modulus;
  } mexp_out_t;

endpackage

// ===== rtl/core/mexp_mulmod.sv =====
// mexp_mulmod: bit-serial interleaved modular multiplier, prod = a * b mod m
// scans b msb first, one double step and one add step per bit; needs a <= m, b < m
// depends on nothing beyond its parameter
`timescale 1ns / 1ps

module mexp_mulmod #(
  parameter int unsigned W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic [W-1:0] m,
  output logic         done,
  output logic [W-1:0] prod
);

  localparam int unsigned CW = $clog2(W);

  logic          busy_r, busy_nxt;
  logic          phase_r, phase_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  r_r, r_nxt;
  logic [W-1:0]  bsh_r, bsh_nxt;
  logic [W:0]    dbl;
  logic [W:0]    sum;
  logic [W:0]    m_ext;

  // one double-and-reduce or add-and-reduce per cycle
  always_comb begin
    busy_nxt  = busy_r;
    phase_nxt = phase_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    r_nxt     = r_r;
    bsh_nxt   = bsh_r;
    m_ext     = {1'b0, m};
    dbl       = {r_r, 1'b0};
    sum       = {1'b0, r_r} + (bsh_r[W-1] ? {1'b0, a} : '0);
    if (start) begin
      busy_nxt  = 1'b1;
      phase_nxt = 1'b0;
      cnt_nxt   = CW'(W - 1);
      r_nxt     = '0;
      bsh_nxt   = b;
    end else if (busy_r) begin
      if (!phase_r) begin
        // r = 2r mod m
        r_nxt     = (dbl >= m_ext) ? W'(dbl - m_ext) : W'(dbl);
        phase_nxt = 1'b1;
      end else begin
        // r = r + a*bit mod m, then move to the next multiplier bit
        r_nxt     = (sum >= m_ext) ? W'(sum - m_ext) : W'(sum);
        phase_nxt = 1'b0;
        bsh_nxt   = {bsh_r[W-2:0], 1'b0};
        cnt_nxt   = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      phase_r <= 1'b0;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      busy_r  <= busy_nxt;
      phase_r <= phase_nxt;
      done_r  <= done_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    r_r   <= r_nxt;
    bsh_r <= bsh_nxt;
  end

  assign done = done_r;
  assign prod = r_r;

endmodule

// ===== rtl/core/modular_exponentiation.sv =====
// modular_exponentiation: base^power mod modulus by right-to-left square-and-multiply
// depends on mexp_pkg (payload types) and mexp_mulmod (two serial multiplier lanes)
//
//   channel | ports                          | payload
//   --------+--------------------------------+------------------------------------
//   input   | in_valid, in_ready, in_data    | base_value, power, modulus
//   result  | out_valid, out_ready, out_data | residue, zero_modulus
//
// one transaction at a time; in_ready is high only while the sequencer is idle
// base reduction is a restoring remainder of base by modulus, one bit a cycle
// each exponent bit up to the highest set one runs the multiply and square lanes
//   side by side, one double-and-reduce or add-and-reduce step per cycle each
// a zero exponent or a zero modulus skips the reduction and goes straight to the result
// reset is synchronous, active low; a stalled result holds in the output register
`timescale 1ns / 1ps

module modular_exponentiation #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned POWER_BITS = 31
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  mexp_pkg::mexp_in_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output mexp_pkg::mexp_out_t out_data
);

  localparam int unsigned VB = VALUE_BITS;
  localparam int unsigned EB = (POWER_BITS < mexp_pkg::FIELD_POWER_BITS) ?
                               POWER_BITS : mexp_pkg::FIELD_POWER_BITS;
  localparam int unsigned CW = $clog2(VB);

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_REDUCE = 3'd1;
  localparam logic [2:0] ST_STEP   = 3'd2;
  localparam logic [2:0] ST_WAIT   = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0]          state_r, state_nxt;
  logic [CW-1:0]       red_cnt_r, red_cnt_nxt;
  logic [VB-1:0]       bsh_r, bsh_nxt;
  logic [VB-1:0]       sq_r, sq_nxt;
  logic [VB-1:0]       acc_r, acc_nxt;
  logic [VB-1:0]       m_r, m_nxt;
  logic [EB-1:0]       e_r, e_nxt;
  logic                flag_r, flag_nxt;
  logic                out_valid_r, out_valid_nxt;
  mexp_pkg::mexp_out_t out_data_r, out_data_nxt;
  logic                lane_start;
  logic                mul_done, sqr_done;
  logic [VB-1:0]       mul_prod, sqr_prod;
  logic [VB:0]         rem_ext;
  logic [VB:0]         m_ext;
  logic [VB-1:0]       in_base, in_mod;
  logic [EB-1:0]       in_pow;

  assign in_base = in_data.base_value[VB-1:0];
  assign in_mod  = in_data.modulus[VB-1:0];
  assign in_pow  = in_data.power[EB-1:0];

  // multiply lane: acc * sq mod m
  mexp_mulmod #(.W(VB)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (lane_start),
    .a     (acc_r),
    .b     (sq_r),
    .m     (m_r),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  // square lane: sq * sq mod m
  mexp_mulmod #(.W(VB)) u_sqr (
    .clk   (clk),
    .rst_n (rst_n),
    .start (lane_start),
    .a     (sq_r),
    .b     (sq_r),
    .m     (m_r),
    .done  (sqr_done),
    .prod  (sqr_prod)
  );

  // sequencer and operand registers
  always_comb begin
    state_nxt     = state_r;
    red_cnt_nxt   = red_cnt_r;
    bsh_nxt       = bsh_r;
    sq_nxt        = sq_r;
    acc_nxt       = acc_r;
    m_nxt         = m_r;
    e_nxt         = e_r;
    flag_nxt      = flag_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    lane_start    = 1'b0;
    rem_ext       = {sq_r, bsh_r[VB-1]};
    m_ext         = {1'b0, m_r};

    // result register drains independently of the sequencer
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          bsh_nxt     = in_base;
          m_nxt       = in_mod;
          e_nxt       = in_pow;
          sq_nxt      = '0;
          acc_nxt     = VB'(1);
          flag_nxt    = 1'b0;
          red_cnt_nxt = CW'(VB - 1);
          if (in_pow == '0) begin
            // zero exponent: unreduced one
            state_nxt = ST_FINISH;
          end else if (in_mod == '0) begin
            acc_nxt   = '0;
            flag_nxt  = 1'b1;
            state_nxt = ST_FINISH;
          end else begin
            state_nxt = ST_REDUCE;
          end
        end
      end
      ST_REDUCE: begin
        // restoring remainder of base by modulus, one bit a cycle
        sq_nxt  = (rem_ext >= m_ext) ? VB'(rem_ext - m_ext) : VB'(rem_ext);
        bsh_nxt = {bsh_r[VB-2:0], 1'b0};
        red_cnt_nxt = red_cnt_r - 1'b1;
        if (red_cnt_r == '0) begin
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        // no set exponent bits left: acc holds the answer
        if (e_r == '0) begin
          state_nxt = ST_FINISH;
        end else begin
          lane_start = 1'b1;
          state_nxt  = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (sqr_done && mul_done) begin
          if (e_r[0]) begin
            acc_nxt = mul_prod;
          end
          sq_nxt    = sqr_prod;
          e_nxt     = e_r >> 1;
          state_nxt = ST_STEP;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.residue      = mexp_pkg::FIELD_VALUE_BITS'(acc_r);
          out_data_nxt.zero_modulus = flag_r;
          state_nxt                 = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      red_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      red_cnt_r   <= red_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    bsh_r      <= bsh_nxt;
    sq_r       <= sq_nxt;
    acc_r      <= acc_nxt;
    m_r        <= m_nxt;
    e_r        <= e_nxt;
    flag_r     <= flag_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== tb/tb_top.sv =====
// tb_top: self-checking testbench for modular_exponentiation, directed table then random operands
// depends on mexp_pkg (payload types) and the modular_exponentiation rtl
`timescale 1ns / 1ps

module tb_top;

  // one directed stimulus row; fixed rows carry a hand-typed result
  typedef struct {
    mexp_pkg::mexp_in_t  operands;
    bit                  fixed;
    mexp_pkg::mexp_out_t want;
  } directed_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  mexp_pkg::mexp_in_t  in_data;
  logic                out_valid;
  logic                out_ready;
  mexp_pkg::mexp_out_t out_data;

  mexp_pkg::mexp_out_t residue_expect_q[$];
  directed_row_t       directed_rows[$];
  int                  error_count = 0;
  bit                  steady      = 1'b0;
  bit                  hold_arm    = 1'b0;

  modular_exponentiation dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // 2 ns clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // base^power mod modulus, right-to-left over the exponent bits, exact 64-bit products
  function automatic mexp_pkg::mexp_out_t power_mod_expect(mexp_pkg::mexp_in_t t);
    logic [63:0]         acc;
    logic [63:0]         sq;
    logic [63:0]         m;
    mexp_pkg::mexp_out_t r;
    int                  i;
    r = '0;
    if (t.power == '0) begin
      r.residue = 32'd1;
    end else if (t.modulus == '0) begin
      r.zero_modulus = 1'b1;
    end else begin
      m   = 64'(t.modulus);
      acc = 64'd1;
      sq  = 64'(t.base_value) % m;
      for (i = 0; i < mexp_pkg::FIELD_POWER_BITS; i++) begin
        if (t.power[i]) acc = (acc * sq) % m;
        sq = (sq * sq) % m;
      end
      r.residue = acc[31:0];
    end
    return r;
  endfunction

  // random operands; mostly short exponents, a few full width
  function automatic mexp_pkg::mexp_in_t draw_operands();
    mexp_pkg::mexp_in_t t;
    int                 sel;
    int                 bits;
    sel = $urandom_range(99);
    if (sel < 7) begin
      t.power = '0;
    end else if (sel < 17) begin
      t.power = 31'($urandom);
    end else begin
      bits    = $urandom_range(1, 10);
      t.power = 31'($urandom) & ((31'd1 << bits) - 31'd1);
    end
    sel = $urandom_range(99);
    if (sel < 6)       t.modulus = '0;
    else if (sel < 10) t.modulus = 32'd1;
    else if (sel < 30) t.modulus = 32'($urandom_range(2, 1000));
    else if (sel < 40) t.modulus = {1'b1, 31'($urandom)};
    else               t.modulus = 32'($urandom);
    sel = $urandom_range(99);
    if (sel < 5)       t.base_value = '0;
    else if (sel < 10) t.base_value = 32'hFFFF_FFFF;
    else if (sel < 15) t.base_value = 32'd1;
    else               t.base_value = 32'($urandom);
    return t;
  endfunction

  task automatic add_row(input logic [31:0] b, input logic [30:0] p, input logic [31:0] m,
                         input bit fixed, input logic [31:0] res, input logic flag);
    directed_row_t row;
    row.operands.base_value = b;
    row.operands.power      = p;
    row.operands.modulus    = m;
    row.fixed               = fixed;
    row.want.residue        = res;
    row.want.zero_modulus   = flag;
    directed_rows.push_back(row);
  endtask

  // offer one transaction, with random idle cycles ahead of it unless steady, and log its expectation
  task automatic send_operands(input mexp_pkg::mexp_in_t t, input bit fixed,
                               input mexp_pkg::mexp_out_t want);
    while (!steady && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (!in_ready);
    residue_expect_q.push_back(fixed ? want : power_mod_expect(t));
  endtask

  // result checker
  always @(posedge clk) begin
    mexp_pkg::mexp_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (residue_expect_q.size() == 0) begin
        $display("%0t: unexpected result residue=%h zero_modulus=%b", $time,
                 out_data.residue, out_data.zero_modulus);
        error_count++;
      end else begin
        want = residue_expect_q.pop_front();
        if (out_data.residue !== want.residue) begin
          $display("%0t: residue expected %h actual %h", $time, want.residue,
                   out_data.residue);
          error_count++;
        end
        if (out_data.zero_modulus !== want.zero_modulus) begin
          $display("%0t: zero_modulus expected %b actual %b", $time, want.zero_modulus,
                   out_data.zero_modulus);
          error_count++;
        end
      end
    end
  end

  // result side: random back-pressure, one long hold-off once armed
  initial begin
    int hold_count;
    bit hold_done;
    hold_done = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && hold_arm && !hold_done) begin
        for (hold_count = 0; hold_count < 1500; hold_count++) begin
          out_ready <= 1'b0;
          @(posedge clk);
        end
        hold_done = 1'b1;
      end
      out_ready <= rst_n && (steady || $urandom_range(99) >= 24);
    end
  end

  // stimulus
  initial begin
    mexp_pkg::mexp_out_t none;
    int                  idx;
    none     = '0;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;

    // zero exponent gives 1 unreduced
    add_row(32'd5,          31'd0,          32'd7,          1, 32'd1, 1'b0);
    add_row(32'd9,          31'd0,          32'd0,          1, 32'd1, 1'b0);
    add_row(32'd9,          31'd0,          32'd1,          1, 32'd1, 1'b0);
    add_row(32'hFFFF_FFFF,  31'd0,          32'hFFFF_FFFF,  1, 32'd1, 1'b0);
    // zero modulus with a nonzero exponent flags and forces 0
    add_row(32'd3,          31'd1,          32'd0,          1, 32'd0, 1'b1);
    add_row(32'hFFFF_FFFF,  31'h7FFF_FFFF,  32'd0,          1, 32'd0, 1'b1);
    // modulus of one
    add_row(32'h123,        31'd5,          32'd1,          1, 32'd0, 1'b0);
    add_row(32'hFFFF_FFFF,  31'h7FFF_FFFF,  32'd1,          1, 32'd0, 1'b0);
    // base extremes
    add_row(32'd0,          31'd1,          32'd13,         1, 32'd0, 1'b0);
    add_row(32'd0,          31'h7FFF_FFFF,  32'hFFFF_FFFF,  1, 32'd0, 1'b0);
    add_row(32'd1,          31'h7FFF_FFFF,  32'hFFFF_FFFF,  1, 32'd1, 1'b0);
    add_row(32'hFFFF_FFFF,  31'd1,          32'hFFFF_FFFF,  1, 32'd0, 1'b0);
    add_row(32'hFFFF_FFFF,  31'd1,          32'hFFFF_FFFE,  1, 32'd1, 1'b0);
    add_row(32'hFFFF_FFFE,  31'd2,          32'hFFFF_FFFF,  1, 32'd1, 1'b0);
    // small hand-checked powers
    add_row(32'd2,          31'd10,         32'd1000,       1, 32'd24, 1'b0);
    add_row(32'd3,          31'd4,          32'd100,        1, 32'd81, 1'b0);
    add_row(32'd7,          31'd1,          32'd2,          1, 32'd1, 1'b0);
    add_row(32'd5,          31'd3,          32'hFFFF_FFFF,  1, 32'd125, 1'b0);
    add_row(32'd2,          31'd32,         32'hFFFF_FFFF,  1, 32'd1, 1'b0);
    // wide operands, predicted
    add_row(32'hFFFF_FFFF,  31'h7FFF_FFFF,  32'hFFFF_FFFB,  0, 32'd0, 1'b0);
    add_row(32'h8000_0000,  31'h4000_0000,  32'hFFFF_FFFD,  0, 32'd0, 1'b0);
    add_row(32'h1234_5678,  31'h5555_5555,  32'h8765_4321,  0, 32'd0, 1'b0);
    add_row(32'hFFFF_FFFF,  31'd2,          32'h0FFF_FFFF,  0, 32'd0, 1'b0);
    add_row(32'hDEAD_BEEF,  31'h2AAA_AAAA,  32'h8000_0000,  0, 32'd0, 1'b0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (directed_rows[i])
      send_operands(directed_rows[i].operands, directed_rows[i].fixed, directed_rows[i].want);

    // pause until the block has drained
    in_valid <= 1'b0;
    while (residue_expect_q.size() != 0) @(posedge clk);

    // random operands; one hold-off on the result side, one stretch with no gaps
    for (idx = 0; idx < 266; idx++) begin
      if (idx == 40) hold_arm = 1'b1;
      steady = (idx >= 150 && idx < 210);
      send_operands(draw_operands(), 1'b0, none);
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    // drain and let any stray result show up
    while (residue_expect_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog
  initial begin
    #6000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/mexp_pkg.sv
rtl/core/mexp_mulmod.sv
rtl/core/modular_exponentiation.sv
tb/tb_top.sv
